// ===== design/bf16pd_pkg.sv =====
// Shared constants and types for the bf16 dot product with projection mapping.
// No dependencies; imported by every module of the block.
package bf16pd_pkg;

  localparam int QKV_COLUMNS  = 8192;
  localparam int Z_COLUMNS    = 4096;
  localparam int GATE_COLUMNS = 32;

  localparam int MAP_W = 18;

  localparam logic [MAP_W-1:0] BASE_Z = MAP_W'(QKV_COLUMNS);
  localparam logic [MAP_W-1:0] BASE_B = MAP_W'(QKV_COLUMNS + Z_COLUMNS);
  localparam logic [MAP_W-1:0] BASE_A = MAP_W'(QKV_COLUMNS + Z_COLUMNS + GATE_COLUMNS);
  localparam logic [MAP_W-1:0] GATE_LIMIT = MAP_W'(GATE_COLUMNS);

  localparam logic [31:0] FP32_QNAN = 32'h7fc0_0000;
  localparam logic [31:0] BF16_BIAS = 32'h0000_7fff;

  typedef enum logic [1:0] {
    PROJ_QKV = 2'd0,
    PROJ_Z   = 2'd1,
    PROJ_B   = 2'd2,
    PROJ_A   = 2'd3
  } proj_t;

  typedef struct packed {
    proj_t       proj;
    logic [12:0] column;
    logic        emit;
  } map_info_t;

endpackage

// ===== design/bf16pd_if.sv =====
// Valid/ready channel interfaces for operand pairs and finished results.
// Depends on bf16pd_pkg for nothing beyond field widths kept in step with it.
interface bf16pd_operand_if;
  logic        valid;
  logic        ready;
  logic [15:0] activation_value;
  logic [15:0] weight_value;
  logic [13:0] output_index;
  logic        last_element;

  modport source (output valid, output activation_value, output weight_value,
                  output output_index, output last_element, input ready);
  modport sink   (input valid, input activation_value, input weight_value,
                  input output_index, input last_element, output ready);
endinterface

interface bf16pd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  projection_select;
  logic [12:0] column_number;
  logic [15:0] result_value;

  modport source (output valid, output projection_select, output column_number,
                  output result_value, input ready);
  modport sink   (input valid, input projection_select, input column_number,
                  input result_value, output ready);
endinterface

// ===== design/bf16pd_mul.sv =====
// bf16 x bf16 multiplier giving an IEEE fp32 product, round to nearest even.
// Depends on bf16pd_pkg.
module bf16pd_mul (
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [31:0] prod
);
  import bf16pd_pkg::*;

  logic               sign;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]         siga, sigb, ea, eb;
  logic [15:0]        p, pn;
  logic [4:0]         lz;
  logic signed [10:0] be;
  logic [10:0]        k;
  logic [4:0]         kk;
  logic [2:0]         sh;
  logic [22:0]        sub_field;
  logic [32:0]        wide;
  logic               up;
  logic [23:0]        rnd_field;

  always_comb begin
    sign   = a[15] ^ b[15];
    a_nan  = (a[14:7] == 8'hff) && (a[6:0] != 7'd0);
    b_nan  = (b[14:7] == 8'hff) && (b[6:0] != 7'd0);
    a_inf  = (a[14:7] == 8'hff) && (a[6:0] == 7'd0);
    b_inf  = (b[14:7] == 8'hff) && (b[6:0] == 7'd0);
    a_zero = (a[14:0] == 15'd0);
    b_zero = (b[14:0] == 15'd0);
    siga   = {a[14:7] != 8'd0, a[6:0]};
    sigb   = {b[14:7] != 8'd0, b[6:0]};
    ea     = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
    eb     = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
    p      = {8'b0, siga} * {8'b0, sigb};
    lz     = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (p[i]) lz = 5'(15 - i);
    end
    pn   = p << lz;
    be   = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({6'b0, lz});
    sh   = 3'(be + 11'sd7);
    k    = 11'(-be - 11'sd7);
    kk   = (k > 11'd17) ? 5'd17 : k[4:0];
    sub_field = {7'b0, pn} << sh;
    wide = {pn, 17'b0} >> kk;
    up   = wide[16] && ((|wide[15:0]) || wide[17]);
    rnd_field = {8'b0, wide[32:17]} + {23'b0, up};

    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      prod = FP32_QNAN;
    end else if (a_inf || b_inf) begin
      prod = {sign, 8'hff, 23'b0};
    end else if (a_zero || b_zero) begin
      prod = {sign, 31'b0};
    end else if (be >= 11'sd255) begin
      prod = {sign, 8'hff, 23'b0};
    end else if (be >= 11'sd1) begin
      prod = {sign, be[7:0], pn[14:0], 8'b0};
    end else if (be >= -11'sd7) begin
      prod = {sign, 8'b0, sub_field};
    end else begin
      prod = {sign, 7'b0, rnd_field};
    end
  end

endmodule

// ===== design/bf16pd_add.sv =====
// fp32 adder, round to nearest even, every NaN result made the canonical quiet NaN.
// Depends on bf16pd_pkg.
module bf16pd_add (
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] sum
);
  import bf16pd_pkg::*;

  logic        x_nan, y_nan, x_inf, y_inf, swap, eff_sub, up;
  logic [31:0] big, sml;
  logic [23:0] bsig, ssig;
  logic [7:0]  bexp, sexp, d;
  logic [26:0] aa, b0, bb, mask;
  logic [27:0] s;
  logic [26:0] r;
  logic [4:0]  lz, sh;
  logic [8:0]  e;
  logic [7:0]  ef;

  always_comb begin
    x_nan = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hff) && (y[22:0] != 23'd0);
    x_inf = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == 8'hff) && (y[22:0] == 23'd0);
    swap  = y[30:0] > x[30:0];
    big   = swap ? y : x;
    sml   = swap ? x : y;
    bsig  = {big[30:23] != 8'd0, big[22:0]};
    ssig  = {sml[30:23] != 8'd0, sml[22:0]};
    bexp  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    sexp  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = bexp - sexp;
    aa    = {bsig, 3'b0};
    b0    = {ssig, 3'b0};
    mask  = (27'd1 << d[4:0]) - 27'd1;
    if (d >= 8'd27) begin
      bb = {26'b0, |ssig};
    end else begin
      bb = (b0 >> d[4:0]) | {26'b0, |(b0 & mask)};
    end
    eff_sub = big[31] ^ sml[31];
    s = eff_sub ? ({1'b0, aa} - {1'b0, bb}) : ({1'b0, aa} + {1'b0, bb});

    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    if (s[27]) begin
      sh = 5'd0;
      r  = {s[27:2], s[1] | s[0]};
      e  = {1'b0, bexp} + 9'd1;
    end else begin
      sh = ({4'b0, lz} < ({1'b0, bexp} - 9'd1)) ? lz : 5'(bexp - 8'd1);
      r  = s[26:0] << sh;
      e  = {1'b0, bexp} - {4'b0, sh};
    end
    ef = r[26] ? e[7:0] : 8'd0;
    up = r[2] && (r[1] || r[0] || r[3]);

    if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
      sum = FP32_QNAN;
    end else if (x_inf) begin
      sum = x;
    end else if (y_inf) begin
      sum = y;
    end else if (s == 28'd0) begin
      sum = {eff_sub ? 1'b0 : big[31], 31'b0};
    end else if (e >= 9'd255) begin
      sum = {big[31], 8'hff, 23'b0};
    end else begin
      sum = {big[31], ef, r[25:3]} + {31'b0, up};
    end
  end

endmodule

// ===== design/bf16pd_map.sv =====
// Maps a global output index onto a projection and a column within it.
// Depends on bf16pd_pkg.
module bf16pd_map (
  input  logic [13:0]           index,
  output bf16pd_pkg::map_info_t info
);
  import bf16pd_pkg::*;

  logic [MAP_W-1:0] idx, col;

  always_comb begin
    idx = MAP_W'(index);
    info.emit = 1'b1;
    priority if (idx < BASE_Z) begin
      info.proj = PROJ_QKV;
      col = idx;
    end else if (idx < BASE_B) begin
      info.proj = PROJ_Z;
      col = idx - BASE_Z;
    end else if (idx < BASE_A) begin
      info.proj = PROJ_B;
      col = idx - BASE_B;
    end else begin
      info.proj = PROJ_A;
      col = idx - BASE_A;
      // past the end of the a projection: the row ends silently
      info.emit = (col < GATE_LIMIT);
    end
    info.column = col[12:0];
  end

endmodule

// ===== design/bf16_dot_product_projection.sv =====
// Top level of the bf16 dot product: operand register stage, fp32 accumulate, result register.
// Depends on bf16pd_pkg, bf16pd_if, bf16pd_mul, bf16pd_add and bf16pd_map.

// One operand transaction (activation and weight, both bf16) is taken every clock cycle unless
// a final element that gives a result stalls behind one not yet taken. The fp32 product is
// formed on the way into a register stage, together with the projection and column decoded
// from the output index; from that register it is added into the fp32 accumulator with round
// to nearest even. The accumulator loop is one fp32 add back into one register. A transaction
// marked last, as it leaves the product stage, loads the sum, rounded to bf16, into the result
// register and clears the accumulator to +0.0 for the next row. Rows whose index lies beyond
// the a projection end without a result.
// Non-final elements keep flowing while a result waits to be taken; only a second final
// element that gives a result stalls behind it.
module bf16_dot_product_projection (
  input  logic                    clk,
  input  logic                    rst,
  bf16pd_operand_if.sink          operand,
  bf16pd_result_if.source         result
);
  import bf16pd_pkg::*;

  // product stage
  logic        prod_valid;
  logic [31:0] prod;
  logic        prod_last;
  map_info_t   prod_info;

  // accumulator and result register
  logic [31:0] acc;
  logic        res_valid;
  logic [1:0]  res_proj;
  logic [12:0] res_col;
  logic [15:0] res_value;

  logic [31:0] prod_next;
  map_info_t   info_next;
  logic [31:0] sum;
  logic [31:0] rounded;
  logic        emit_now;
  logic        advance;
  logic        take;

  bf16pd_mul u_mul (
    .a    (operand.activation_value),
    .b    (operand.weight_value),
    .prod (prod_next)
  );

  bf16pd_map u_map (
    .index (operand.output_index),
    .info  (info_next)
  );

  bf16pd_add u_add (
    .x   (acc),
    .y   (prod),
    .sum (sum)
  );

  // integer bf16 rounding: add 0x7fff plus the kept lsb, wrap, keep the upper half
  assign rounded = sum + BF16_BIAS + {31'b0, sum[16]};

  assign emit_now = prod_last && prod_info.emit;
  // advance the product stage unless it holds a result the full output register blocks
  assign advance  = prod_valid && (!emit_now || !res_valid || result.ready);
  assign take     = operand.valid && operand.ready;

  assign operand.ready = !prod_valid || advance;

  assign result.valid             = res_valid;
  assign result.projection_select = res_proj;
  assign result.column_number     = res_col;
  assign result.result_value      = res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= 32'd0;
      res_valid  <= 1'b0;
    end else begin
      if (take) begin
        prod_valid <= 1'b1;
      end else if (advance) begin
        prod_valid <= 1'b0;
      end
      if (advance) begin
        // drop back to +0.0 at the end of every row
        acc <= prod_last ? 32'd0 : sum;
      end
      if (advance && emit_now) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload: hold unless a new transaction or result loads it
  always_ff @(posedge clk) begin
    if (take) begin
      prod      <= prod_next;
      prod_last <= operand.last_element;
      prod_info <= info_next;
    end
    if (advance && emit_now) begin
      res_proj  <= prod_info.proj;
      res_col   <= prod_info.column;
      res_value <= rounded[31:16];
    end
  end

endmodule
